### hdl/bech_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bech_pkg
// Shared constants, types and the polymod step for the bech32 encoder.
// ----------------------------------------------------------------------------
package bech_pkg;

  localparam int MAX_HRP_LEN = 83;
  localparam int HRP_AW      = (MAX_HRP_LEN > 1) ? $clog2(MAX_HRP_LEN) : 1;
  localparam int CNT_W       = $clog2(MAX_HRP_LEN + 1);
  localparam int CHECK_W     = 30;

  localparam logic [7:0] SEP_CHAR = 8'h31;

  localparam logic [CHECK_W-1:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef enum logic [1:0] {
    OP_HRP  = 2'd0,
    OP_DATA = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_HRP  = 2'd0,
    PH_OVER = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_SEP,
    ST_DATA,
    ST_END,
    ST_ZERO,
    ST_CSUM
  } state_e;

  function automatic logic [CHECK_W-1:0] poly_step(input logic [CHECK_W-1:0] c,
                                                   input logic [4:0] v);
    logic [CHECK_W-1:0] r;
    logic [4:0]         top;
    top = c[CHECK_W-1 -: 5];
    r   = {c[CHECK_W-6:0], v};
    for (int k = 0; k < 5; k++) begin
      if (top[k]) begin
        r = r ^ GEN[k];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [4:0] g);
    return ALPHABET[8 * (31 - int'(g)) +: 8];
  endfunction

endpackage

### hdl/bech_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bech_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bech_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bech32_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bech32_encoder_unit
// Streaming bech32 string encoder: hrp characters, data bytes, end item.
// ----------------------------------------------------------------------------
// An hrp character is echoed; the low five bits of the first 83 go to an
// 83-entry store. The first data or end item of a message replays that store
// through the single read port, one polymod step per cycle, before the
// separator (an empty or overlong hrp instead gives a final status result).
// Then a data byte gives one or two output characters, one per cycle while
// the slot is free, and the end item a pad group if bits remain, six zero
// steps and six checksum characters. One output register sits on the result
// side, so a stalled result holds the block while the next work needs it.
module bech32_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic       final_res_o,
  output logic       status_o
);
  import bech_pkg::*;

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [CHECK_W-1:0]   check_q, check_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [3:0]           res_q, res_d;
  logic [2:0]           rc_q, rc_d;
  logic [11:0]          acc_q, acc_d;
  logic [3:0]           bits_q, bits_d;
  logic [2:0]           step_q, step_d;
  logic [1:0]           op_q, op_d;
  logic [7:0]           val_q, val_d;

  logic                 out_valid_q;
  logic [7:0]           sym_q;
  logic                 fin_q;
  logic                 st_q;

  logic                 load;
  logic [7:0]           ld_sym;
  logic                 ld_fin;
  logic                 ld_st;

  logic                 slot_free;
  logic                 in_xfer;
  logic                 ram_we;
  logic                 ram_re;
  logic [4:0]           ram_rdata;
  logic [4:0]           data_grp;
  logic [4:0]           pad_grp;
  logic [3:0]           bits_rem;
  logic [3:0]           res_mask;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign data_grp = 5'(acc_q >> (bits_q - 4'd5));
  assign pad_grp  = 5'({1'b0, res_q} << (3'd5 - rc_q));
  assign bits_rem = bits_q - 4'd5;
  assign res_mask = 4'((5'd1 << bits_rem) - 5'd1);

  bech_ram #(
    .WIDTH(5),
    .DEPTH(MAX_HRP_LEN),
    .AW   (HRP_AW)
  ) u_hrp_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[HRP_AW-1:0]),
    .wdata_i(value_i[4:0]),
    .re_i   (ram_re),
    .raddr_i(idx_q[HRP_AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    check_d = check_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    res_d   = res_q;
    rc_d    = rc_q;
    acc_d   = acc_q;
    bits_d  = bits_q;
    step_d  = step_q;
    op_d    = op_q;
    val_d   = val_q;
    load    = 1'b0;
    ld_sym  = 8'd0;
    ld_fin  = 1'b0;
    ld_st   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d  = op_i;
          val_d = value_i;
          unique case (op_i) inside
            OP_HRP: begin
              if (phase_q != PH_DATA) begin
                if ((phase_q == PH_HRP) && (cnt_q < CNT_W'(MAX_HRP_LEN))) begin
                  check_d = poly_step(check_q, {3'd0, value_i[6:5]});
                  ram_we  = 1'b1;
                  cnt_d   = cnt_q + 1'b1;
                end else begin
                  phase_d = PH_OVER;
                end
                load   = 1'b1;
                ld_sym = value_i;
              end
            end
            OP_DATA, OP_END: begin
              if (phase_q != PH_DATA) begin
                if ((phase_q == PH_OVER) || (cnt_q == '0)) begin
                  load    = 1'b1;
                  ld_fin  = 1'b1;
                  ld_st   = 1'b1;
                  check_d = CHECK_W'(1);
                  cnt_d   = '0;
                  res_d   = '0;
                  rc_d    = '0;
                  phase_d = PH_HRP;
                end else begin
                  check_d = poly_step(check_q, 5'd0);
                  idx_d   = '0;
                  state_d = ST_MIX;
                end
              end else if (op_i == OP_DATA) begin
                acc_d   = {res_q, value_i};
                bits_d  = 4'd8 + {1'b0, rc_q};
                state_d = ST_DATA;
              end else begin
                state_d = ST_END;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MIX: begin
        if (pend_q) begin
          check_d = poly_step(check_q, ram_rdata);
        end
        if (idx_q < cnt_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else if (!pend_q) begin
          state_d = ST_SEP;
        end
      end

      ST_SEP: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_sym  = SEP_CHAR;
          phase_d = PH_DATA;
          if (op_q == OP_DATA) begin
            acc_d   = {res_q, val_q};
            bits_d  = 4'd8 + {1'b0, rc_q};
            state_d = ST_DATA;
          end else begin
            state_d = ST_END;
          end
        end
      end

      ST_DATA: begin
        if (slot_free) begin
          check_d = poly_step(check_q, data_grp);
          load    = 1'b1;
          ld_sym  = alpha_char(data_grp);
          bits_d  = bits_rem;
          if (bits_rem < 4'd5) begin
            res_d   = acc_q[3:0] & res_mask;
            rc_d    = bits_rem[2:0];
            state_d = ST_IDLE;
          end
        end
      end

      ST_END: begin
        if (rc_q != '0) begin
          if (slot_free) begin
            check_d = poly_step(check_q, pad_grp);
            load    = 1'b1;
            ld_sym  = alpha_char(pad_grp);
            rc_d    = '0;
          end
        end else begin
          step_d  = '0;
          state_d = ST_ZERO;
        end
      end

      ST_ZERO: begin
        check_d = poly_step(check_q, 5'd0);
        step_d  = step_q + 1'b1;
        if (step_q == 3'd5) begin
          check_d = poly_step(check_q, 5'd0) ^ CHECK_W'(1);
          step_d  = '0;
          state_d = ST_CSUM;
        end
      end

      ST_CSUM: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_sym  = alpha_char(check_q[CHECK_W-1 -: 5]);
          ld_fin  = (step_q == 3'd5);
          check_d = {check_q[CHECK_W-6:0], 5'd0};
          step_d  = step_q + 1'b1;
          if (step_q == 3'd5) begin
            check_d = CHECK_W'(1);
            cnt_d   = '0;
            res_d   = '0;
            rc_d    = '0;
            phase_d = PH_HRP;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HRP;
      check_q     <= CHECK_W'(1);
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      res_q       <= '0;
      rc_q        <= '0;
      bits_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      check_q <= check_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      res_q   <= res_d;
      rc_q    <= rc_d;
      bits_q  <= bits_d;
      step_q  <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    op_q  <= op_d;
    val_q <= val_d;
    if (load) begin
      sym_q <= ld_sym;
      fin_q <= ld_fin;
      st_q  <= ld_st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign final_res_o = fin_q;
  assign status_o    = st_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_HRP_LEN))
    else $error("hrp count beyond store depth");

  a_mix_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> (idx_q <= cnt_q))
    else $error("replay index past hrp count");

  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q != '0))
    else $error("data phase with empty hrp");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> slot_free)
    else $error("result loaded while output slot is held");
`endif

endmodule
